// ----- design/bitn_pkg.sv -----
// shared types and constants for the binary image thinning block
package bitn_pkg;

    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;
    localparam int KIND_W = 2;
    localparam int PIX_W  = 8;
    localparam int PASS_W = 10;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd480;
    localparam logic [PIX_W-1:0]  FG_THRESH    = 8'd128;
    localparam logic [PIX_W-1:0]  PIX_ON       = 8'd255;
    localparam logic [PIX_W-1:0]  PIX_OFF      = 8'd0;
    localparam logic [PASS_W-1:0] PASS_MAX     = 10'd1023;
    localparam logic [3:0]        B_MIN        = 4'd2;
    localparam logic [3:0]        B_MAX        = 4'd6;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_RUN,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fg;
    } cmd_t;

endpackage

// ----- design/bitn_ram.sv -----
// generic single-write, single-read ram with registered read data
module bitn_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/bitn_front.sv -----
// front end: accepts input transactions, classifies them, two-entry command queue
module bitn_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bitn_pkg::KIND_W-1:0] kind,
    input  logic [bitn_pkg::PIX_W-1:0]  pixel_value,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output bitn_pkg::cmd_t              cmd
);

    bitn_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    bitn_pkg::cmd_t new_cmd;
    logic           known;
    logic           push;
    logic           pop;

    always_comb
    begin
        new_cmd.fg = (pixel_value >= bitn_pkg::FG_THRESH);
        new_cmd.op = bitn_pkg::OP_LOAD;
        known      = 1'b1;
        unique case (kind)
            bitn_pkg::KIND_LOAD: new_cmd.op = bitn_pkg::OP_LOAD;
            bitn_pkg::KIND_RUN:  new_cmd.op = bitn_pkg::OP_RUN;
            bitn_pkg::KIND_READ: new_cmd.op = bitn_pkg::OP_READ;
            default:             known      = 1'b0;
        endcase
    end

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && known;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- design/bitn_back.sv -----
// back end: frame memories, load/read access and the thinning sweep sequencer
module bitn_back #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cmd_valid,
    output logic                                          cmd_ready,
    input  bitn_pkg::cmd_t                                cmd,
    input  logic [$clog2(MAX_COLS+1)-1:0]                 w,
    input  logic [$clog2(MAX_ROWS+1)-1:0]                 h,
    input  logic [$clog2(MAX_COLS*MAX_ROWS+1)-1:0]        n,
    input  logic                                          pos_clear,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [bitn_pkg::PIX_W-1:0]                    pixel_out,
    output logic [bitn_pkg::PASS_W-1:0]                   pass_count
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int CI    = $clog2(MAX_COLS);
    localparam int RI    = $clog2(MAX_ROWS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDW    = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_WR     = 3'd3;
    localparam logic [2:0] ST_SUBEND = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [3:0] K_FIRST  = 4'd0;
    localparam logic [3:0] K_CENTER = 4'd8;
    localparam logic [3:0] K_LAST   = 4'd9;

    logic [2:0]                 state_reg, state_next;
    logic                       cur_reg, cur_next;
    logic                       sub_reg, sub_next;
    logic                       cleared_reg, cleared_next;
    logic                       fg_reg, fg_next;
    logic [bitn_pkg::PASS_W-1:0] passes_reg, passes_next;
    logic [RI-1:0]              r_reg, r_next;
    logic [CI-1:0]              c_reg, c_next;
    logic [AW-1:0]              p_reg, p_next;
    logic [3:0]                 k_reg, k_next;
    logic [3:0]                 kstart_reg, kstart_next;
    logic [8:0]                 nb_reg, nb_next;
    logic [AW-1:0]              load_pos_reg, load_pos_next;
    logic [AW-1:0]              read_pos_reg, read_pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bitn_pkg::PIX_W-1:0] pixel_out_reg, pixel_out_next;
    logic [bitn_pkg::PASS_W-1:0] pass_count_reg, pass_count_next;

    logic [1:0]    we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic [AW-1:0] raddr;
    logic [1:0]    rdata;
    logic          rdata_sel;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] wa;
    logic          slot_free;
    logic          mark;
    logic          new_v;
    logic          changed;
    logic          last_c;
    logic          last_r;
    logic [3:0]    cnt_a;
    logic [3:0]    cnt_b;
    logic          m1;
    logic          m2;

    function automatic logic is_interior(input logic [RI-1:0] rr, input logic [CI-1:0] cc,
                                         input logic [CW-1:0] ww, input logic [HW-1:0] hh);
        logic [HW:0] r2;
        logic [CW:0] c2;
        r2 = (HW+1)'(rr) + (HW+1)'(2);
        c2 = (CW+1)'(cc) + (CW+1)'(2);
        return (rr != '0) && (cc != '0) && (r2 <= (HW+1)'(hh)) && (c2 <= (CW+1)'(ww));
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < 2; gi++)
        begin : g_frame
            bitn_ram #(
                .WIDTH (1),
                .DEPTH (DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (we[gi]),
                .waddr (waddr),
                .wdata (wdata),
                .raddr (raddr),
                .rdata (rdata[gi])
            );
        end
    endgenerate

    assign rdata_sel = rdata[cur_reg];
    assign wa        = AW'(w);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (k_reg)
            4'd0:    nb_addr = p_reg - wa;
            4'd1:    nb_addr = p_reg - wa + AW'(1);
            4'd2:    nb_addr = p_reg + AW'(1);
            4'd3:    nb_addr = p_reg + wa + AW'(1);
            4'd4:    nb_addr = p_reg + wa;
            4'd5:    nb_addr = p_reg + wa - AW'(1);
            4'd6:    nb_addr = p_reg - AW'(1);
            4'd7:    nb_addr = p_reg - wa - AW'(1);
            default: nb_addr = p_reg;
        endcase
    end

    // zhang-suen mark from the captured 3x3 window
    always_comb
    begin
        cnt_a = 4'd0;
        cnt_b = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            cnt_b = cnt_b + 4'(nb_reg[i]);
            if (!nb_reg[i] && nb_reg[(i + 1) % 8])
            begin
                cnt_a = cnt_a + 4'd1;
            end
        end
        if (!sub_reg)
        begin
            m1 = nb_reg[0] & nb_reg[2] & nb_reg[4];
            m2 = nb_reg[2] & nb_reg[4] & nb_reg[6];
        end
        else
        begin
            m1 = nb_reg[0] & nb_reg[2] & nb_reg[6];
            m2 = nb_reg[0] & nb_reg[4] & nb_reg[6];
        end
        mark  = (cnt_a == 4'd1) && (cnt_b >= bitn_pkg::B_MIN) && (cnt_b <= bitn_pkg::B_MAX)
                && !m1 && !m2;
        new_v = nb_reg[8] & ~((kstart_reg == K_FIRST) && mark);
    end

    assign last_c  = ((CW'(c_reg) + CW'(1)) == w);
    assign last_r  = ((HW'(r_reg) + HW'(1)) == h);
    assign changed = (passes_reg == '0) ? fg_reg : cleared_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        sub_next        = sub_reg;
        cleared_next    = cleared_reg;
        fg_next         = fg_reg;
        passes_next     = passes_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        kstart_next     = kstart_reg;
        nb_next         = nb_reg;
        load_pos_next   = load_pos_reg;
        read_pos_next   = read_pos_reg;
        out_valid_next  = out_valid_reg;
        pixel_out_next  = pixel_out_reg;
        pass_count_next = pass_count_reg;
        cmd_ready       = 1'b0;
        we              = 2'b00;
        waddr           = load_pos_reg;
        wdata           = cmd.fg;
        raddr           = read_pos_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        bitn_pkg::OP_LOAD:
                        begin
                            if (n != '0)
                            begin
                                we[cur_reg] = 1'b1;
                                if ((NW'(load_pos_reg) + NW'(1)) == n)
                                begin
                                    load_pos_next = '0;
                                end
                                else
                                begin
                                    load_pos_next = load_pos_reg + AW'(1);
                                end
                            end
                        end
                        bitn_pkg::OP_READ:
                        begin
                            state_next = ST_RDW;
                        end
                        default:
                        begin
                            load_pos_next = '0;
                            read_pos_next = '0;
                            passes_next   = '0;
                            cleared_next  = 1'b0;
                            fg_next       = 1'b0;
                            r_next        = '0;
                            c_next        = '0;
                            p_next        = '0;
                            k_next        = K_CENTER;
                            kstart_next   = K_CENTER;
                            if (n == '0)
                            begin
                                sub_next   = 1'b1;
                                state_next = ST_SUBEND;
                            end
                            else
                            begin
                                sub_next   = 1'b0;
                                state_next = ST_SWEEP;
                            end
                        end
                    endcase
                end
            end
            ST_RDW:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    pass_count_next = '0;
                    pixel_out_next  = bitn_pkg::PIX_OFF;
                    if (n != '0)
                    begin
                        pixel_out_next = rdata_sel ? bitn_pkg::PIX_ON : bitn_pkg::PIX_OFF;
                        if ((NW'(read_pos_reg) + NW'(1)) == n)
                        begin
                            read_pos_next = '0;
                        end
                        else
                        begin
                            read_pos_next = read_pos_reg + AW'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                raddr = nb_addr;
                if (k_reg > kstart_reg)
                begin
                    nb_next[k_reg - 4'd1] = rdata_sel;
                end
                if (k_reg == K_LAST)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_WR:
            begin
                we[~cur_reg] = 1'b1;
                waddr        = p_reg;
                wdata        = new_v;
                cleared_next = cleared_reg | (nb_reg[8] & ~new_v);
                if (sub_reg)
                begin
                    fg_next = fg_reg | new_v;
                end
                p_next = p_reg + AW'(1);
                if (last_c)
                begin
                    c_next = '0;
                    r_next = r_reg + RI'(1);
                end
                else
                begin
                    c_next = c_reg + CI'(1);
                end
                kstart_next = is_interior(r_next, c_next, w, h) ? K_FIRST : K_CENTER;
                k_next      = kstart_next;
                if (last_c && last_r)
                begin
                    state_next = ST_SUBEND;
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SUBEND:
            begin
                // an empty frame makes no sweep, so the banks stay as they are
                if (n != '0)
                begin
                    cur_next = ~cur_reg;
                end
                r_next      = '0;
                c_next      = '0;
                p_next      = '0;
                k_next      = K_CENTER;
                kstart_next = K_CENTER;
                if (!sub_reg)
                begin
                    sub_next   = 1'b1;
                    state_next = ST_SWEEP;
                end
                else
                begin
                    if (passes_reg != bitn_pkg::PASS_MAX)
                    begin
                        passes_next = passes_reg + bitn_pkg::PASS_W'(1);
                    end
                    if (changed)
                    begin
                        sub_next     = 1'b0;
                        cleared_next = 1'b0;
                        fg_next      = 1'b0;
                        state_next   = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    pixel_out_next  = bitn_pkg::PIX_OFF;
                    pass_count_next = passes_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pos_clear)
        begin
            load_pos_next = '0;
            read_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= 1'b0;
            sub_reg       <= 1'b0;
            cleared_reg   <= 1'b0;
            fg_reg        <= 1'b0;
            passes_reg    <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            p_reg         <= '0;
            k_reg         <= K_CENTER;
            kstart_reg    <= K_CENTER;
            load_pos_reg  <= '0;
            read_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            sub_reg       <= sub_next;
            cleared_reg   <= cleared_next;
            fg_reg        <= fg_next;
            passes_reg    <= passes_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            kstart_reg    <= kstart_next;
            load_pos_reg  <= load_pos_next;
            read_pos_reg  <= read_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg         <= nb_next;
        pixel_out_reg  <= pixel_out_next;
        pass_count_reg <= pass_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign pass_count = pass_count_reg;

`ifndef ASSERT_OFF
    a_sweep_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (NW'(p_reg) < n))
        else $error("sweep address outside frame");

    a_load_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (n != '0) |-> (NW'(load_pos_reg) < n))
        else $error("load position outside frame");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (CW'(c_reg) < w))
        else $error("sweep column outside frame");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE || $past(state_reg) == ST_RDW))
        else $error("result raised outside read or run completion");
`endif

endmodule

// ----- design/binary_image_thinning.sv -----
// top level of the binary image thinning block
// Zhang-Suen thinning of one binary frame held in two 1-bit frame memories (ping-pong).
// A load is written from the idle state; a read waits in its own state for the read data.
// A run makes passes until one leaves the image unchanged, or, for the first pass, until
// no foreground remains; each pass is two sweeps of the frame. Border pixels fetch just
// their own bit, interior pixels the 3x3 window, one bit a cycle via the single read port.
// A two-entry command queue separates input acceptance from execution. Frame memories
// are not cleared; pixels must be loaded before they are read or thinned.
module binary_image_thinning #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bitn_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bitn_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bitn_pkg::KIND_W-1:0]  kind,
    input  logic [bitn_pkg::PIX_W-1:0]   pixel_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bitn_pkg::PIX_W-1:0]   pixel_out,
    output logic [bitn_pkg::PASS_W-1:0]  pass_count
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int HW = $clog2(MAX_ROWS + 1);
    localparam int NW = $clog2(MAX_COLS * MAX_ROWS + 1);

    logic [bitn_pkg::CFG_W-1:0] frame_width_reg;
    logic [bitn_pkg::CFG_W-1:0] frame_height_reg;
    logic [CW-1:0]              eff_w;
    logic [HW-1:0]              eff_h;
    logic [NW-1:0]              n_pix;
    logic                       cfg_write;
    logic                       pos_clear;
    logic                       cmd_valid;
    logic                       cmd_ready;
    bitn_pkg::cmd_t             cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign pos_clear = cfg_write && ((cfg_index == bitn_pkg::REG_FRAME_WIDTH)
                                     || (cfg_index == bitn_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bitn_pkg::WIDTH_RESET;
            frame_height_reg <= bitn_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bitn_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                bitn_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // saturate to the frame memory geometry
    assign eff_w = (32'(frame_width_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(frame_width_reg);
    assign eff_h = (32'(frame_height_reg) > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(frame_height_reg);
    assign n_pix = NW'(eff_w) * NW'(eff_h);

    bitn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .pixel_value (pixel_value),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    bitn_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .w          (eff_w),
        .h          (eff_h),
        .n          (n_pix),
        .pos_clear  (pos_clear),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .pass_count (pass_count)
    );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for binary_image_thinning: random frames, run and read transactions
`timescale 1ns / 100ps

module tb;

    localparam logic [bitn_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int STORE_N   = 1048576;
    localparam int DIM_MAX   = 1024;
    localparam int IDLE_LIMIT = 400000;
    localparam int SEG_ITEMS = 215;

    typedef struct {
        logic [bitn_pkg::KIND_W-1:0] knd;
        logic [bitn_pkg::PIX_W-1:0]  pix;
    } item_t;

    typedef struct {
        logic [bitn_pkg::PIX_W-1:0]  pix;
        logic [bitn_pkg::PASS_W-1:0] passes;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bitn_pkg::IDX_W-1:0] cfg_index = '0;
    logic [bitn_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [bitn_pkg::KIND_W-1:0] kind = '0;
    logic [bitn_pkg::PIX_W-1:0] pixel_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [bitn_pkg::PIX_W-1:0] pixel_out;
    logic [bitn_pkg::PASS_W-1:0] pass_count;

    item_t   pending_q[$];
    result_t result_q[$];
    int snd_idle = 0;
    int rcv_idle = 0;
    int errors = 0;
    int issued = 0;
    int stall_cnt = 0;

    // frame model
    bit frame_bits[0:STORE_N-1];
    bit snap_bits[0:STORE_N-1];
    int cols_reg = bitn_pkg::WIDTH_RESET;
    int rows_reg = bitn_pkg::HEIGHT_RESET;
    int load_pos = 0;
    int read_pos = 0;

    binary_image_thinning DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .pixel_value(pixel_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_out(pixel_out),
        .pass_count(pass_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_cols();
        return cols_reg > DIM_MAX ? DIM_MAX : cols_reg;
    endfunction

    function automatic int eff_rows();
        return rows_reg > DIM_MAX ? DIM_MAX : rows_reg;
    endfunction

    function automatic bit thin_sweep(int w, int h, bit second);
        bit cleared;
        bit nb[8];
        int a, b, idx;
        bit m1, m2;
        cleared = 0;
        if (w < 3 || h < 3)
            return 0;
        for (int i = 0; i < w * h; i++)
            snap_bits[i] = frame_bits[i];
        for (int r = 1; r + 1 < h; r++)
        begin
            for (int c = 1; c + 1 < w; c++)
            begin
                idx = r * w + c;
                if (!snap_bits[idx])
                    continue;
                nb[0] = snap_bits[idx - w];
                nb[1] = snap_bits[idx - w + 1];
                nb[2] = snap_bits[idx + 1];
                nb[3] = snap_bits[idx + w + 1];
                nb[4] = snap_bits[idx + w];
                nb[5] = snap_bits[idx + w - 1];
                nb[6] = snap_bits[idx - 1];
                nb[7] = snap_bits[idx - w - 1];
                a = 0;
                b = 0;
                for (int k = 0; k < 8; k++)
                begin
                    b += nb[k];
                    if (!nb[k] && nb[(k + 1) % 8])
                        a++;
                end
                if (!second)
                begin
                    m1 = nb[0] & nb[2] & nb[4];
                    m2 = nb[2] & nb[4] & nb[6];
                end
                else
                begin
                    m1 = nb[0] & nb[2] & nb[6];
                    m2 = nb[0] & nb[4] & nb[6];
                end
                if (a == 1 && b >= bitn_pkg::B_MIN && b <= bitn_pkg::B_MAX && !m1 && !m2)
                begin
                    frame_bits[idx] = 0;
                    cleared = 1;
                end
            end
        end
        return cleared;
    endfunction

    function automatic int thin_passes();
        int w, h, passes;
        bit c0, c1, changed;
        w = eff_cols();
        h = eff_rows();
        passes = 0;
        do
        begin
            c0 = thin_sweep(w, h, 0);
            c1 = thin_sweep(w, h, 1);
            if (passes == 0)
            begin
                changed = 0;
                for (int i = 0; i < w * h; i++)
                    if (frame_bits[i])
                        changed = 1;
            end
            else
                changed = c0 || c1;
            passes++;
        end
        while (changed);
        return passes > int'(bitn_pkg::PASS_MAX) ? int'(bitn_pkg::PASS_MAX) : passes;
    endfunction

    function automatic void predict_thinning(logic [bitn_pkg::KIND_W-1:0] k,
                                             logic [bitn_pkg::PIX_W-1:0] v);
        int n;
        result_t res;
        n = eff_cols() * eff_rows();
        res.pix = bitn_pkg::PIX_OFF;
        res.passes = '0;
        case (k)
            bitn_pkg::KIND_LOAD:
                if (n != 0)
                begin
                    if (load_pos >= n)
                        load_pos = 0;
                    frame_bits[load_pos] = (v >= bitn_pkg::FG_THRESH);
                    load_pos++;
                    if (load_pos >= n)
                        load_pos = 0;
                end
            bitn_pkg::KIND_RUN:
            begin
                res.passes = bitn_pkg::PASS_W'(thin_passes());
                load_pos = 0;
                read_pos = 0;
                result_q.insert(result_q.size(), res);
            end
            bitn_pkg::KIND_READ:
            begin
                if (n != 0)
                begin
                    if (read_pos >= n)
                        read_pos = 0;
                    res.pix = frame_bits[read_pos] ? bitn_pkg::PIX_ON : bitn_pkg::PIX_OFF;
                    read_pos++;
                    if (read_pos >= n)
                        read_pos = 0;
                end
                result_q.insert(result_q.size(), res);
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin : driver
        item_t it;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_thinning(kind, pixel_value);
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle)
                begin
                    it = pending_q.pop_front();
                    in_valid <= 1'b1;
                    kind <= it.knd;
                    pixel_value <= it.pix;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        result_t exp_r;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= rcv_idle);
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction pixel_out=%0d pass_count=%0d",
                             $time, pixel_out, pass_count);
                    errors++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (pixel_out !== exp_r.pix)
                    begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, exp_r.pix, pixel_out);
                        errors++;
                    end
                    if (pass_count !== exp_r.passes)
                    begin
                        $display("%0t: pass_count expected %0d actual %0d",
                                 $time, exp_r.passes, pass_count);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_item(logic [bitn_pkg::KIND_W-1:0] k, logic [bitn_pkg::PIX_W-1:0] v);
        item_t it;
        it.knd = k;
        it.pix = v;
        pending_q.insert(pending_q.size(), it);
        issued++;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || in_valid || result_q.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [bitn_pkg::IDX_W-1:0] idx, logic [bitn_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bitn_pkg::REG_FRAME_WIDTH)
            cols_reg = val;
        else
            rows_reg = val;
        load_pos = 0;
        read_pos = 0;
    endtask

    task automatic set_frame(int w, int h);
        write_reg(bitn_pkg::REG_FRAME_WIDTH, bitn_pkg::CFG_W'(w));
        write_reg(bitn_pkg::REG_FRAME_HEIGHT, bitn_pkg::CFG_W'(h));
    endtask

    function automatic logic [bitn_pkg::PIX_W-1:0] grey(int density);
        if ($urandom_range(99) < density)
            return bitn_pkg::PIX_W'($urandom_range(255, 128));
        return bitn_pkg::PIX_W'($urandom_range(127, 0));
    endfunction

    // full frame load, then optional run, then reads, with some noise
    task automatic frame_job(int density, int nreads, bit do_run);
        int n;
        n = eff_cols() * eff_rows();
        for (int i = 0; i < n; i++)
        begin
            push_item(bitn_pkg::KIND_LOAD, grey(density));
            if ($urandom_range(99) < 3)
                push_item(KIND_NONE, bitn_pkg::PIX_W'($urandom));
        end
        if (do_run)
            push_item(bitn_pkg::KIND_RUN, bitn_pkg::PIX_W'($urandom));
        for (int i = 0; i < nreads; i++)
            push_item(bitn_pkg::KIND_READ, bitn_pkg::PIX_W'($urandom));
    endtask

    // leading part of a frame loaded and read back, no run
    task automatic partial_job(int density, int count);
        for (int i = 0; i < count; i++)
            push_item(bitn_pkg::KIND_LOAD, grey(density));
        for (int i = 0; i < count; i++)
            push_item(bitn_pkg::KIND_READ, bitn_pkg::PIX_W'($urandom));
    endtask

    initial
    begin : stimulus
        int n, dens;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3 frame with grey extremes, then reloaded all foreground and run
        set_frame(3, 3);
        push_item(bitn_pkg::KIND_LOAD, 8'd0);
        push_item(bitn_pkg::KIND_LOAD, 8'd127);
        push_item(bitn_pkg::KIND_LOAD, 8'd128);
        push_item(bitn_pkg::KIND_LOAD, 8'd255);
        push_item(KIND_NONE, 8'd255);
        for (int i = 0; i < 5; i++)
            push_item(bitn_pkg::KIND_LOAD, 8'd200);
        for (int i = 0; i < 4; i++)
            push_item(bitn_pkg::KIND_READ, 8'd0);
        for (int i = 0; i < 9; i++)
            push_item(bitn_pkg::KIND_LOAD, 8'd255);
        push_item(bitn_pkg::KIND_RUN, 8'd0);
        for (int i = 0; i < 10; i++)
            push_item(bitn_pkg::KIND_READ, 8'd0);
        drain();

        // zero width: nothing stored, reads answer 0
        set_frame(0, 5);
        push_item(bitn_pkg::KIND_LOAD, 8'd255);
        push_item(bitn_pkg::KIND_READ, 8'd0);
        push_item(bitn_pkg::KIND_RUN, 8'd0);
        push_item(bitn_pkg::KIND_READ, 8'd0);
        drain();

        // no interior
        set_frame(2, 5);
        frame_job(60, 12, 1);
        drain();

        // oversized width and height saturate
        set_frame(2047, 3);
        partial_job(70, 30);
        drain();
        set_frame(3, 2047);
        partial_job(70, 30);
        drain();
        set_frame(6, 6);

        issued = 0;
        for (int s = 0; s < 3; s++)
        begin
            snd_idle = (s == 0) ? 9 : (s == 1) ? 78 : 0;
            rcv_idle = (s == 0) ? 78 : (s == 1) ? 9 : 0;
            while (issued < (s + 1) * SEG_ITEMS)
            begin
                if ($urandom_range(99) < 40)
                begin
                    drain();
                    set_frame($urandom_range(10, 3), $urandom_range(10, 3));
                end
                n = eff_cols() * eff_rows();
                case ($urandom_range(2))
                    0: dens = 25;
                    1: dens = 55;
                    default: dens = 85;
                endcase
                frame_job(dens, ($urandom_range(3) == 0) ? $urandom_range(n, 1) : n,
                          $urandom_range(3) != 0);
            end
            drain();
        end
        rcv_idle = 0;
        snd_idle = 0;
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
